// ===== rtl/tbst_pkg.sv =====
// Shared types and constants for the temperature band switch tracker.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tbst_pkg;

  localparam int SAMPLE_BITS_DEF = 12;

  localparam int CAL_CODE_W  = 12;
  localparam int CAL_TEMP_W  = 8;
  localparam int SLOPE_W     = 4;
  localparam int SETTLE_W    = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  localparam int STATUS_W = 2;
  localparam int TEMP_W   = 8;
  localparam int BAND_W   = 4;
  localparam int RUN_W    = 8;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_CAL_CODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CAL_TEMP = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOPE    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE   = 2'd3;

  localparam logic [SLOPE_W-1:0]  SLOPE_RESET  = 4'd10;
  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 8'd50;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ADC_NOK = 2'd1;
  localparam logic [STATUS_W-1:0] ST_HOT    = 2'd2;

  localparam int TEMP_FLOOR_LIMIT = -40;
  localparam int TEMP_FLOOR_VALUE = -39;
  localparam int TEMP_HIGH_START  = 120;
  localparam int TEMP_HIGH_LIMIT  = 150;
  localparam int TEMP_HIGH_VALUE  = 119;
  localparam int BAND_OFFSET      = 40;

  // Division by the band width of 20 degrees as x * 205 >> 12, exact for x below 160.
  localparam int BAND_RECIP = 205;
  localparam int BAND_SHIFT = 12;

  typedef struct packed {
    logic load;   // capture a new word and start the divide
    logic step;   // one restoring divide step
    logic temp;   // form and clamp the temperature
    logic emit;   // update band tracking and load the output register
  } tbst_cmd_t;

  typedef struct packed {
    logic div_last;  // the current divide step is the final one
    logic out_free;  // the output register can take a word this cycle
  } tbst_stat_t;

endpackage

`default_nettype wire

// ===== rtl/temperature_band_switch_tracker_top.sv =====
// Top level of the temperature band switch tracker.
// Instantiates tbst_ctrl and tbst_dp; depends on tbst_pkg.
//
// Usage:
//   Input stream (s_*): one word per ADC conversion. s_tdata carries the raw
//   sample, s_tuser the ADC ok flag. Output stream (m_*): one word per input
//   word, with the status code in m_tuser and temperature, active band and
//   recalibration flag in m_tdata. The cfg_* port writes the calibration code,
//   calibration temperature, slope and settle count; write only while idle.
//   Timing: a word is taken only when the block is idle. The slope divide is
//   a restoring divider that yields one quotient bit per cycle; the S_TEMP
//   state then clamps the temperature and S_EMIT updates the band tracker
//   and loads the output register, after which the block returns to idle
//   and the next word can be taken.
//   The output register holds a finished word while the receiver stalls; a
//   new input word is still accepted and worked on, and the block waits with
//   its result only when the previous word has not yet been taken.
//   Reset (rst, synchronous) clears the band tracker, empties the output
//   register and restores the configuration register defaults.
`timescale 1ns / 1ps
`default_nettype none

module temperature_band_switch_tracker_top #(
  parameter int SAMPLE_BITS = tbst_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [tbst_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [tbst_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // s_tdata: sample in the low SAMPLE_BITS bits, zero padded.
  input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // s_tuser: adc_ok.
  input  wire logic                                s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // m_tdata: temp_clamped [7:0], active_band_out [11:8], recal [12], zeros above.
  output logic [15:0]                              m_tdata,
  // m_tuser: status.
  output logic [tbst_pkg::STATUS_W-1:0]            m_tuser
);
  import tbst_pkg::*;

  localparam int S_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int M_PAD_W  = 16 - TEMP_W - BAND_W - 1;

  tbst_cmd_t  cmd;
  tbst_stat_t stat;

  logic [TEMP_W-1:0] temp_clamped;
  logic [BAND_W-1:0] active_band_out;
  logic              recal;

  tbst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tbst_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .sample          (s_tdata[SAMPLE_BITS-1:0]),
    .adc_ok          (s_tuser),
    .m_tready        (m_tready),
    .m_tvalid        (m_tvalid),
    .status          (m_tuser),
    .temp_clamped    (temp_clamped),
    .active_band_out (active_band_out),
    .recal           (recal),
    .cmd             (cmd),
    .stat            (stat)
  );

  assign m_tdata = {{M_PAD_W{1'b0}}, recal, active_band_out, temp_clamped};

  // Padding bits of the input word carry nothing; the shift leaves only them.
  logic unused_pad;
  assign unused_pad = ^(s_tdata >> SAMPLE_BITS);

endmodule

`default_nettype wire

// ===== rtl/tbst_ctrl.sv =====
// Controller state machine for the temperature band switch tracker.
// Depends on tbst_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module tbst_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire tbst_pkg::tbst_stat_t stat,
  output tbst_pkg::tbst_cmd_t    cmd
);
  import tbst_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_TEMP = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid) state_next = S_DIV;
      S_DIV:  if (stat.div_last) state_next = S_TEMP;
      S_TEMP: state_next = S_EMIT;
      S_EMIT: if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // No word is taken while reset is held.
  assign s_tready = (state == S_IDLE) && !rst;

  assign cmd = '{load: s_tready && s_tvalid,
                 step: (state == S_DIV),
                 temp: (state == S_TEMP),
                 emit: (state == S_EMIT) && stat.out_free};

endmodule

`default_nettype wire

// ===== rtl/tbst_dp.sv =====
// Datapath of the temperature band switch tracker: configuration registers,
// serial divider, clamp, band tracking and output register. Depends on tbst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbst_dp #(
  parameter int SAMPLE_BITS = tbst_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [tbst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tbst_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [SAMPLE_BITS-1:0]        sample,
  input  wire logic                          adc_ok,
  input  wire logic                          m_tready,
  output logic                               m_tvalid,
  output logic [tbst_pkg::STATUS_W-1:0]      status,
  output logic [tbst_pkg::TEMP_W-1:0]        temp_clamped,
  output logic [tbst_pkg::BAND_W-1:0]        active_band_out,
  output logic                               recal,
  input  wire tbst_pkg::tbst_cmd_t           cmd,
  output tbst_pkg::tbst_stat_t               stat
);
  import tbst_pkg::*;

  localparam int MAG_W = (SAMPLE_BITS > CAL_CODE_W) ? SAMPLE_BITS : CAL_CODE_W;
  localparam int D_W   = MAG_W + 1;
  localparam int T_W   = MAG_W + 2;
  localparam int CNT_W = $clog2(MAG_W);
  localparam int PROD_W = 16;

  localparam logic signed [T_W-1:0] FLOOR_LIMIT = T_W'(TEMP_FLOOR_LIMIT);
  localparam logic signed [T_W-1:0] HIGH_START  = T_W'(TEMP_HIGH_START);
  localparam logic signed [T_W-1:0] HIGH_LIMIT  = T_W'(TEMP_HIGH_LIMIT);

  // Configuration registers.
  logic [CAL_CODE_W-1:0] cal_code;
  logic [CAL_TEMP_W-1:0] cal_temp;
  logic [SLOPE_W-1:0]    slope;
  logic [SETTLE_W-1:0]   settle_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_code     <= '0;
      cal_temp     <= '0;
      slope        <= SLOPE_RESET;
      settle_count <= SETTLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAL_CODE: cal_code     <= cfg_data[CAL_CODE_W-1:0];
        REG_CAL_TEMP: cal_temp     <= cfg_data[CAL_TEMP_W-1:0];
        REG_SLOPE:    slope        <= cfg_data[SLOPE_W-1:0];
        REG_SETTLE:   settle_count <= cfg_data[SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Restoring divider on the magnitude of cal_code - sample, one quotient bit a cycle.
  logic [MAG_W-1:0]   quo;
  logic [SLOPE_W-1:0] rem;
  logic [CNT_W-1:0]   cnt;
  logic               neg;
  logic               ok;

  logic [D_W-1:0]     diff;
  logic [D_W-1:0]     diff_abs;
  logic [SLOPE_W-1:0] divisor;
  logic [SLOPE_W:0]   trial;
  logic               ge;

  assign diff     = D_W'(cal_code) - D_W'(sample);
  assign diff_abs = diff[D_W-1] ? (~diff + D_W'(1)) : diff;
  assign divisor  = (slope == '0) ? SLOPE_W'(1) : slope;
  assign trial    = {rem, quo[MAG_W-1]};
  assign ge       = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo <= diff_abs[MAG_W-1:0];
      rem <= '0;
      cnt <= CNT_W'(MAG_W - 1);
      neg <= diff[D_W-1];
      ok  <= adc_ok;
    end else if (cmd.step) begin
      quo <= {quo[MAG_W-2:0], ge};
      rem <= ge ? SLOPE_W'(trial - {1'b0, divisor}) : trial[SLOPE_W-1:0];
      cnt <= cnt - CNT_W'(1);
    end
  end

  // Temperature and clamp.
  logic [T_W-1:0]        t_raw;
  logic signed [T_W-1:0] t_s;
  logic [STATUS_W-1:0]   st_reg;
  logic [TEMP_W-1:0]     t_reg;

  assign t_raw = neg ? (T_W'(cal_temp) - T_W'(quo)) : (T_W'(cal_temp) + T_W'(quo));
  assign t_s   = $signed(t_raw);

  always_ff @(posedge clk) begin
    if (cmd.temp) begin
      if (!ok) begin
        st_reg <= ST_ADC_NOK;
        t_reg  <= '0;
      end else if (t_s > HIGH_LIMIT) begin
        st_reg <= ST_HOT;
        t_reg  <= '0;
      end else if (t_s < FLOOR_LIMIT) begin
        st_reg <= ST_OK;
        t_reg  <= TEMP_W'(TEMP_FLOOR_VALUE);
      end else if (t_s >= HIGH_START) begin
        st_reg <= ST_OK;
        t_reg  <= TEMP_W'(TEMP_HIGH_VALUE);
      end else begin
        st_reg <= ST_OK;
        t_reg  <= t_raw[TEMP_W-1:0];
      end
    end
  end

  // Band tracking.
  logic [BAND_W-1:0] last_band;
  logic [RUN_W-1:0]  run_count;
  logic [BAND_W-1:0] active_band;

  logic [TEMP_W-1:0] band_x;
  logic [PROD_W-1:0] band_prod;
  logic [BAND_W-1:0] band;
  logic [RUN_W-1:0]  run_next;
  logic              switch_now;

  // The clamped temperature plus 40 lies in 0 to 159, so it fits unsigned in eight bits.
  assign band_x     = t_reg + TEMP_W'(BAND_OFFSET);
  assign band_prod  = PROD_W'(band_x) * PROD_W'(BAND_RECIP);
  assign band       = BAND_W'(band_prod >> BAND_SHIFT) + BAND_W'(1);
  assign run_next   = (band == last_band) ? (run_count + RUN_W'(1)) : '0;
  assign switch_now = (run_next == settle_count) && (active_band != band);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_band   <= '0;
      run_count   <= '0;
      active_band <= '0;
    end else if (cmd.emit && (st_reg == ST_OK)) begin
      last_band <= band;
      if (switch_now) begin
        active_band <= band;
        run_count   <= '0;
      end else begin
        run_count <= run_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status       <= st_reg;
      temp_clamped <= t_reg;
      if ((st_reg == ST_OK) && switch_now) begin
        active_band_out <= band;
        recal           <= 1'b1;
      end else begin
        active_band_out <= active_band;
        recal           <= 1'b0;
      end
    end
  end

  assign stat = '{div_last: (cnt == '0), out_free: (!m_tvalid || m_tready)};

endmodule

`default_nettype wire
